// ----- sv/tmas_pkg.sv -----
// Package for the trajectory moving-average smoother.
// Holds the sequencer state type, the lane control struct and fixed widths.
// No dependencies.
package tmas_pkg;

	localparam int POS_W = 40;
	localparam int SHIFT_W = 20;
	localparam int ANGLE_W = 19;
	localparam int RADIUS_W = 6;
	localparam int FRAMES_W = 32;
	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 6'd30;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_SUM,
		ST_DRAIN,
		ST_DIVS,
		ST_DIV,
		ST_RES,
		ST_OUT
	} seq_state_t;

	typedef struct packed {
		logic upd;
		logic clr;
		logic rd;
		logic hit;
		logic sum_clr;
		logic div_start;
		logic div_step;
		logic res;
	} lane_ctl_t;

endpackage

// ----- sv/tmas_lane.sv -----
// One channel lane: saturating trajectory accumulator, trajectory and motion rings,
// window sum, restoring divider and corrected result.
// Depends on tmas_pkg.
module tmas_lane import tmas_pkg::*; #(
	parameter int W = 20,
	parameter int RING = 65,
	parameter int AW = 7,
	parameter int CW = 7,
	parameter int SW = 47
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lane_ctl_t           ctl,
	input  logic [AW-1:0]       wr_addr,
	input  logic [AW-1:0]       rd_addr,
	input  logic [CW-1:0]       cnt,
	input  logic signed [W-1:0] din,
	output logic signed [W-1:0] res
);

	localparam int VW = SW + 2;

	logic signed [POS_W-1:0] acc_q;
	logic [POS_W:0] acc_sum;
	logic signed [POS_W-1:0] acc_new;
	logic signed [POS_W-1:0] traj_mem [RING];
	logic signed [W-1:0] mot_mem [RING];
	logic signed [POS_W-1:0] traj_rd_s1;
	logic signed [W-1:0] mot_rd_s1;
	logic rd_s1;
	logic hit_s1;
	logic signed [SW-1:0] sum_q;
	logic signed [POS_W-1:0] traj_slot_q;
	logic signed [W-1:0] mot_slot_q;
	logic neg_q;
	logic [SW-1:0] mag_q;
	logic [CW-1:0] rem_q;
	logic [CW:0] rem_sh;
	logic rem_ge;
	logic [SW-1:0] avg;
	logic [VW-1:0] v;
	logic signed [W-1:0] res_q;

	assign acc_sum = {acc_q[POS_W-1], acc_q} + {{(POS_W+1-W){din[W-1]}}, din};
	always_comb begin
		if (acc_sum[POS_W] != acc_sum[POS_W-1]) begin
			acc_new = acc_sum[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
		end else begin
			acc_new = acc_sum[POS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			rd_s1 <= 1'b0;
			hit_s1 <= 1'b0;
		end else begin
			rd_s1 <= ctl.rd;
			hit_s1 <= ctl.hit;
			if (ctl.upd) begin
				acc_q <= ctl.clr ? '0 : acc_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.upd) begin
			traj_mem[wr_addr] <= acc_new;
			mot_mem[wr_addr] <= din;
		end
		if (ctl.rd) begin
			traj_rd_s1 <= traj_mem[rd_addr];
			mot_rd_s1 <= mot_mem[rd_addr];
		end
	end

	assign rem_sh = {rem_q, mag_q[SW-1]};
	assign rem_ge = rem_sh >= {1'b0, cnt};
	assign avg = neg_q ? (~mag_q + 1'b1) : mag_q;
	assign v = {{2{avg[SW-1]}}, avg} + {{(VW-W){mot_slot_q[W-1]}}, mot_slot_q}
		- {{(VW-POS_W){traj_slot_q[POS_W-1]}}, traj_slot_q};

	always_ff @(posedge clk) begin
		if (ctl.sum_clr) begin
			sum_q <= '0;
		end else if (rd_s1) begin
			sum_q <= sum_q + {{(SW-POS_W){traj_rd_s1[POS_W-1]}}, traj_rd_s1};
		end
		if (hit_s1) begin
			traj_slot_q <= traj_rd_s1;
			mot_slot_q <= mot_rd_s1;
		end
		if (ctl.div_start) begin
			neg_q <= sum_q[SW-1];
			mag_q <= sum_q[SW-1] ? (~sum_q + 1'b1) : sum_q;
			rem_q <= '0;
		end else if (ctl.div_step) begin
			rem_q <= rem_ge ? CW'(rem_sh - {1'b0, cnt}) : rem_sh[CW-1:0];
			mag_q <= {mag_q[SW-2:0], rem_ge};
		end
		if (ctl.res) begin
			if (v[VW-1:W-1] != {(VW-W+1){v[VW-1]}}) begin
				res_q <= v[VW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
			end else begin
				res_q <= v[W-1:0];
			end
		end
	end

	assign res = res_q;

endmodule

// ----- sv/tmas_seq.sv -----
// Sequencer: frame count, ring pointer, latched radius and the per-result
// window pass, divide and output hand-off. Depends on tmas_pkg.
module tmas_seq import tmas_pkg::*; #(
	parameter int MAX_RADIUS = 32,
	parameter int RING = 65,
	parameter int AW = 7,
	parameter int CW = 7,
	parameter int RW = 6,
	parameter int SW = 47
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                final_frame,
	input  logic [RADIUS_W-1:0] radius,
	input  logic                out_free,
	output logic                in_stall,
	output lane_ctl_t           ctl,
	output logic [AW-1:0]       wr_addr,
	output logic [AW-1:0]       rd_addr,
	output logic [CW-1:0]       cnt,
	output logic                load,
	output logic                last
);

	localparam int DCW = $clog2(SW);

	seq_state_t state_q, state_d;
	logic [AW-1:0] head_q;
	logic [AW-1:0] ptr_q;
	logic [FRAMES_W-1:0] fs_q;
	logic [FRAMES_W-1:0] fs_e_q;
	logic [FRAMES_W-1:0] fs_new;
	logic [FRAMES_W-1:0] bav;
	logic [RW-1:0] act_q;
	logic [RW-1:0] r_use;
	logic [RW-1:0] d_q;
	logic [RW-1:0] back;
	logic final_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] k_q;
	logic [DCW-1:0] dc_q;
	logic accept;
	logic emit_now;

	assign accept = in_valid && (state_q == ST_IDLE);
	assign in_stall = state_q != ST_IDLE;
	assign wr_addr = (head_q == AW'(RING - 1)) ? '0 : head_q + 1'b1;
	assign rd_addr = ptr_q;
	assign cnt = cnt_q;
	assign last = final_q && (d_q == '0);
	assign r_use = (fs_q != '0) ? act_q :
		((32'(radius) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radius));
	assign fs_new = (fs_q == '1) ? fs_q : fs_q + 1'b1;
	assign emit_now = (fs_new > 32'(r_use)) || final_frame;
	assign bav = fs_e_q - 32'd1 - 32'(d_q);
	assign back = (bav < 32'(act_q)) ? bav[RW-1:0] : act_q;

	always_comb begin
		state_d = state_q;
		ctl = '0;
		load = 1'b0;
		ctl.upd = accept;
		ctl.clr = final_frame;
		case (state_q)
			ST_IDLE: begin
				if (accept && emit_now) begin
					state_d = ST_SETUP;
				end
			end
			ST_SETUP: begin
				ctl.sum_clr = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				ctl.rd = 1'b1;
				ctl.hit = CW'(d_q) == k_q;
				if (k_q == cnt_q - 1'b1) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_DIVS;
			ST_DIVS: begin
				ctl.div_start = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				ctl.div_step = 1'b1;
				if (dc_q == DCW'(SW - 1)) begin
					state_d = ST_RES;
				end
			end
			ST_RES: begin
				ctl.res = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					load = 1'b1;
					state_d = (final_q && d_q != '0) ? ST_SETUP : ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q <= '0;
			ptr_q <= '0;
			fs_q <= '0;
			fs_e_q <= '0;
			act_q <= '0;
			d_q <= '0;
			final_q <= 1'b0;
			cnt_q <= '0;
			k_q <= '0;
			dc_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				head_q <= wr_addr;
				act_q <= r_use;
				fs_e_q <= fs_new;
				fs_q <= final_frame ? '0 : fs_new;
				final_q <= final_frame;
				d_q <= (fs_new > 32'(r_use)) ? r_use : RW'(fs_new - 32'd1);
			end
			case (state_q)
				ST_SETUP: begin
					cnt_q <= CW'(d_q) + CW'(back) + 1'b1;
					ptr_q <= head_q;
					k_q <= '0;
				end
				ST_SUM: begin
					ptr_q <= (ptr_q == '0) ? AW'(RING - 1) : ptr_q - 1'b1;
					k_q <= k_q + 1'b1;
				end
				ST_DIVS: dc_q <= '0;
				ST_DIV: dc_q <= dc_q + 1'b1;
				ST_OUT: begin
					if (out_free && final_q && d_q != '0) begin
						d_q <= d_q - 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

// ----- sv/trajectory_moving_average_smoother_top.sv -----
// Top level of the trajectory moving-average smoother.
// Instantiates the sequencer, three channel lanes and the output merge register.
// Depends on tmas_pkg, tmas_seq and tmas_lane.
//
// An input item (shift_x, shift_y, angle, final_frame) is accepted when in_valid
// is high and in_stall is low. Result items leave on out_valid/out_stall.
// Write window_radius with window_radius_we only while the block is idle; the
// block does not enforce this. The radius takes effect with the next sequence.
// The x, y and angle lanes run in lockstep. For each result the sequencer reads
// the window from the ring memories, one entry a cycle, then runs a restoring
// divide, one quotient bit a cycle. An item that produces no result does not
// stall the input; the final frame produces up to R+1 results for radius R.
// Results lag the input by R frames.
// The finished result sits in an output register, so a stalled receiver only
// holds back the next result. Reset clears the trajectory, frame count and
// radius (to 30); the ring memories need no clearing.
module trajectory_moving_average_smoother_top import tmas_pkg::*; #(
	parameter int MAX_RADIUS = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       window_radius_we,
	input  logic [RADIUS_W-1:0]        window_radius,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SHIFT_W-1:0]  shift_x,
	input  logic signed [SHIFT_W-1:0]  shift_y,
	input  logic signed [ANGLE_W-1:0]  angle,
	input  logic                       final_frame,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SHIFT_W-1:0]  smooth_shift_x,
	output logic signed [SHIFT_W-1:0]  smooth_shift_y,
	output logic signed [ANGLE_W-1:0]  smooth_angle,
	output logic                       last_of_sequence
);

	localparam int RING = 2 * MAX_RADIUS + 1;
	localparam int AW = $clog2(RING);
	localparam int CW = $clog2(RING + 1);
	localparam int RW = $clog2(MAX_RADIUS + 1);
	localparam int SW = POS_W + CW;

	logic [RADIUS_W-1:0] radius_q;
	lane_ctl_t ctl;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic [CW-1:0] cnt;
	logic load;
	logic last;
	logic out_free;
	logic out_valid_q;
	logic signed [SHIFT_W-1:0] res_x;
	logic signed [SHIFT_W-1:0] res_y;
	logic signed [ANGLE_W-1:0] res_a;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
		end else if (window_radius_we) begin
			radius_q <= window_radius;
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	tmas_seq #(
		.MAX_RADIUS(MAX_RADIUS), .RING(RING), .AW(AW), .CW(CW), .RW(RW), .SW(SW)
	) u_seq (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .final_frame(final_frame),
		.radius(radius_q), .out_free(out_free), .in_stall(in_stall), .ctl(ctl),
		.wr_addr(wr_addr), .rd_addr(rd_addr), .cnt(cnt), .load(load), .last(last)
	);

	tmas_lane #(.W(SHIFT_W), .RING(RING), .AW(AW), .CW(CW), .SW(SW)) u_lane_x (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .wr_addr(wr_addr), .rd_addr(rd_addr),
		.cnt(cnt), .din(shift_x), .res(res_x)
	);

	tmas_lane #(.W(SHIFT_W), .RING(RING), .AW(AW), .CW(CW), .SW(SW)) u_lane_y (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .wr_addr(wr_addr), .rd_addr(rd_addr),
		.cnt(cnt), .din(shift_y), .res(res_y)
	);

	tmas_lane #(.W(ANGLE_W), .RING(RING), .AW(AW), .CW(CW), .SW(SW)) u_lane_a (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .wr_addr(wr_addr), .rd_addr(rd_addr),
		.cnt(cnt), .din(angle), .res(res_a)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			smooth_shift_x <= res_x;
			smooth_shift_y <= res_y;
			smooth_angle <= res_a;
			last_of_sequence <= last;
		end
	end

	assign out_valid = out_valid_q;

`ifndef ASSERT_OFF
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!out_valid_q || !out_stall))
		else $error("result loaded over an untaken result");
	a_load_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> in_stall)
		else $error("result loaded while accepting an item");
	a_accept_ctl: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.upd |-> !(ctl.rd || ctl.div_step || ctl.res))
		else $error("lane update overlaps window pass");
`endif

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for trajectory_moving_average_smoother_top.
// Drives frame sequences under several window radii and checks every
// corrected motion result. Depends on tmas_pkg and the RTL of the block.
module tb;
	import tmas_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_RADIUS = 32;
	localparam int RING = 2 * MAX_RADIUS + 1;

	typedef struct packed {
		logic signed [SHIFT_W-1:0] sx;
		logic signed [SHIFT_W-1:0] sy;
		logic signed [ANGLE_W-1:0] sa;
		logic last;
	} motion_result_t;

	class smoother_scoreboard;
		logic [RADIUS_W-1:0] radius_reg = RADIUS_RESET;
		longint traj_sum[3];
		longint traj_ring[RING][3];
		longint motion_ring[RING][3];
		int unsigned frame_count;
		int unsigned ring_ptr;
		int unsigned live_radius;
		motion_result_t corrected_q[$];
		int errors;

		task report(string what, longint got, longint want);
			$display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
			errors++;
		endtask

		function longint clip(longint v, int w);
			longint hi;
			hi = (64'sd1 <<< (w - 1)) - 1;
			if (v > hi) return hi;
			if (v < -hi - 1) return -hi - 1;
			return v;
		endfunction

		function void corrected_frame(int unsigned d, bit last);
			int unsigned back, ahead, slot, s;
			longint total[3];
			longint cnt, avg;
			longint v[3];
			motion_result_t r;
			back = frame_count - 1 - d;
			if (back > live_radius) back = live_radius;
			ahead = (d < live_radius) ? d : live_radius;
			slot = (ring_ptr + RING - d) % RING;
			total = '{0, 0, 0};
			cnt = ahead + back + 1;
			for (int unsigned off = d - ahead; off <= d + back; off++) begin
				s = (ring_ptr + RING - off) % RING;
				for (int c = 0; c < 3; c++) total[c] += traj_ring[s][c];
			end
			for (int c = 0; c < 3; c++) begin
				avg = total[c] / cnt;
				v[c] = motion_ring[slot][c] + avg - traj_ring[slot][c];
			end
			r.sx = SHIFT_W'(clip(v[0], SHIFT_W));
			r.sy = SHIFT_W'(clip(v[1], SHIFT_W));
			r.sa = ANGLE_W'(clip(v[2], ANGLE_W));
			r.last = last;
			corrected_q = {corrected_q, r};
		endfunction

		function void note_frame(logic signed [SHIFT_W-1:0] dx, logic signed [SHIFT_W-1:0] dy,
				logic signed [ANGLE_W-1:0] da, logic fin);
			longint m[3];
			int d;
			m[0] = dx;
			m[1] = dy;
			m[2] = da;
			if (frame_count == 0) live_radius = (radius_reg > MAX_RADIUS) ? MAX_RADIUS : radius_reg;
			ring_ptr = (ring_ptr + 1) % RING;
			for (int c = 0; c < 3; c++) begin
				traj_sum[c] = clip(traj_sum[c] + m[c], POS_W);
				traj_ring[ring_ptr][c] = traj_sum[c];
				motion_ring[ring_ptr][c] = m[c];
			end
			if (frame_count != 32'hFFFF_FFFF) frame_count++;
			if (frame_count > live_radius) corrected_frame(live_radius, fin && live_radius == 0);
			if (fin) begin
				d = (frame_count > live_radius) ? int'(live_radius) - 1 : int'(frame_count) - 1;
				for (; d >= 0; d--) corrected_frame(d, d == 0);
				traj_sum = '{0, 0, 0};
				frame_count = 0;
			end
		endfunction

		task check_result(motion_result_t got);
			motion_result_t want;
			if (corrected_q.size() == 0) begin
				$display("%0t: result item with none expected", $time);
				errors++;
				return;
			end
			want = corrected_q.pop_front();
			if (got.sx !== want.sx) report("smooth_shift_x", got.sx, want.sx);
			if (got.sy !== want.sy) report("smooth_shift_y", got.sy, want.sy);
			if (got.sa !== want.sa) report("smooth_angle", got.sa, want.sa);
			if (got.last !== want.last) report("last_of_sequence", got.last, want.last);
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic window_radius_we = 0;
	logic [RADIUS_W-1:0] window_radius = '0;
	logic in_valid = 0;
	logic in_stall;
	logic signed [SHIFT_W-1:0] shift_x = '0;
	logic signed [SHIFT_W-1:0] shift_y = '0;
	logic signed [ANGLE_W-1:0] angle = '0;
	logic final_frame = 0;
	logic out_valid;
	logic out_stall = 0;
	logic signed [SHIFT_W-1:0] smooth_shift_x;
	logic signed [SHIFT_W-1:0] smooth_shift_y;
	logic signed [ANGLE_W-1:0] smooth_angle;
	logic last_of_sequence;

	smoother_scoreboard sb = new();
	int send_pct = 0;
	int recv_pct = 0;
	int hold_cycles = 0;
	int frames_sent = 0;

	trajectory_moving_average_smoother_top #(.MAX_RADIUS(MAX_RADIUS)) uut (.*);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result('{smooth_shift_x, smooth_shift_y, smooth_angle, last_of_sequence});
	end

	function automatic longint pick_field(int w);
		longint hi;
		hi = (64'sd1 <<< (w - 1)) - 1;
		case ($urandom_range(0, 7))
			0: return hi;
			1: return -hi - 1;
			2: return 0;
			3: return longint'($urandom_range(0, 2000)) - 1000;
			default: return longint'($urandom) - (longint'(1) <<< 31);
		endcase
	endfunction

	task automatic send_frame(longint x, longint y, longint a, bit fin);
		in_valid <= 1'b1;
		shift_x <= x[SHIFT_W-1:0];
		shift_y <= y[SHIFT_W-1:0];
		angle <= a[ANGLE_W-1:0];
		final_frame <= fin;
		do @(posedge clk); while (in_stall);
		sb.note_frame(shift_x, shift_y, angle, final_frame);
		frames_sent++;
		if ($urandom_range(0, 99) < send_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic send_random_frames(int n, bit close_sequence);
		for (int i = 0; i < n; i++)
			send_frame(pick_field(SHIFT_W), pick_field(SHIFT_W), pick_field(ANGLE_W),
				close_sequence && i == n - 1);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.corrected_q.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic set_radius(logic [RADIUS_W-1:0] r);
		wait_idle();
		window_radius_we <= 1'b1;
		window_radius <= r;
		@(posedge clk);
		window_radius_we <= 1'b0;
		sb.radius_reg = r;
	endtask

	initial begin
		longint hx, hy, ha;
		int len;
		hx = (64'sd1 <<< (SHIFT_W - 1)) - 1;
		ha = (64'sd1 <<< (ANGLE_W - 1)) - 1;
		hy = hx;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Short sequence under the reset radius: the window is clipped on both sides.
		send_frame(hx, -hy - 1, ha, 1'b0);
		send_frame(-hx - 1, hy, -ha - 1, 1'b0);
		send_frame(0, 0, 0, 1'b1);
		set_radius(6'd0);
		send_frame(hx, -hy - 1, -ha - 1, 1'b0);
		send_frame(123, -77, 5, 1'b1);
		set_radius(6'd63);
		repeat (3) send_frame(hx, hy, ha, 1'b0);
		send_frame(hx, hy, ha, 1'b1);
		set_radius(6'd2);
		send_random_frames(3, 1'b0);
		set_radius(6'd5);
		send_random_frames(3, 1'b1);
		set_radius(6'd1);
		send_frame(-hx - 1, -hy - 1, -ha - 1, 1'b1);

		frames_sent = 0;
		while (frames_sent < 130) begin
			if (frames_sent < 43) begin
				send_pct = 37;
				recv_pct = 54;
			end else if (frames_sent < 86) begin
				send_pct = 54;
				recv_pct = 37;
			end else begin
				send_pct = 0;
				recv_pct = 0;
			end
			case ($urandom_range(0, 9))
				0: set_radius(6'd0);
				1: set_radius(6'd32);
				2: set_radius(6'($urandom_range(33, 63)));
				3: set_radius(6'($urandom));
				4, 5: set_radius(6'($urandom_range(1, 4)));
				default: ;
			endcase
			len = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
			if (frames_sent >= 86 && frames_sent < 100 && hold_cycles == 0) begin
				@(posedge clk);
				hold_cycles <= 400;
				len = 30;
			end
			send_random_frames(len, 1'b1);
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.corrected_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.errors == 0)
			$display("** trajectory_moving_average_smoother_top: PASSED **");
		else
			$display("** trajectory_moving_average_smoother_top: FAILED **");
		$finish;
	end

	initial begin
		#2ms;
		$display("** trajectory_moving_average_smoother_top: FAILED **");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/tmas_pkg.sv
sv/tmas_lane.sv
sv/tmas_seq.sv
sv/trajectory_moving_average_smoother_top.sv
test/tb.sv
